// ===== hdl/multi_axis_dda_step_generator_assert.svh =====
// Assertion macros for the multi-axis DDA step generator.
// No dependencies; included by the top level, the only module that carries assertions.
`ifndef MULTI_AXIS_DDA_STEP_GENERATOR_ASSERT_SVH
`define MULTI_AXIS_DDA_STEP_GENERATOR_ASSERT_SVH

`ifndef SYNTHESIS
// Checked on the rising clock edge, off while reset is asserted.
`define MAD_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked on every rising clock edge, reset included.
`define MAD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define MAD_ASSERT(lbl, clk, rst_n, prop, msg)
`define MAD_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// ===== hdl/mad_pkg.sv =====
// Shared types and constants for the multi-axis DDA step generator.
// No dependencies; imported by mad_axis and the top level.
package mad_pkg;

  // Defaults for the top-level parameters
  localparam int unsigned AXES_DEF       = 4;
  localparam int unsigned COUNT_BITS_DEF = 32;

  // Fixed field widths of the stream payloads
  localparam int unsigned AXES_MAX    = 4;
  localparam int unsigned FIELD_W     = 32;
  localparam int unsigned MASK_W      = 4;
  localparam int unsigned TICK_W      = 32;

  // Input tdata layout: four axis deltas, move length, direction mask
  localparam int unsigned LEN_LSB     = AXES_MAX * FIELD_W;
  localparam int unsigned DIR_LSB     = LEN_LSB + FIELD_W;
  localparam int unsigned IN_BITS     = DIR_LSB + MASK_W;
  localparam int unsigned IN_TDATA_W  = ((IN_BITS + 7) / 8) * 8;

  // Output tdata layout: step mask, directions, busy, tick index
  localparam int unsigned STEP_LSB    = 0;
  localparam int unsigned DOUT_LSB    = STEP_LSB + MASK_W;
  localparam int unsigned BUSY_BIT    = DOUT_LSB + MASK_W;
  localparam int unsigned TICK_LSB    = BUSY_BIT + 1;
  localparam int unsigned OUT_BITS    = TICK_LSB + TICK_W;
  localparam int unsigned OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

  // Item kinds carried on s_axis_tuser
  typedef enum logic {
    MAD_OP_TICK  = 1'b0,
    MAD_OP_START = 1'b1
  } mad_op_e;

  // Control from the sequencer to one axis
  typedef struct packed {
    logic load;   // start of a new move
    logic tick;   // step interval while the move is live
  } mad_axis_ctrl_t;

  // Status from one axis back to the sequencer
  typedef struct packed {
    logic step;     // step pulse on this tick
    logic pending;  // steps still left after this item
  } mad_axis_stat_t;

endpackage

// ===== hdl/mad_axis.sv =====
// One DDA axis: accumulator, remaining step count and step decision.
// Depends on mad_pkg.
module mad_axis
  import mad_pkg::*;
#(
  parameter int unsigned COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  mad_axis_ctrl_t        ctrl_i,
  input  logic [COUNT_BITS-1:0] delta_i,
  input  logic [COUNT_BITS-1:0] len_i,
  output mad_axis_stat_t        stat_o
);

  localparam int unsigned ACC_W = COUNT_BITS + 2;

  logic [ACC_W-1:0]      acc_q, acc_d;
  logic [ACC_W-1:0]      back_q, back_d;  // move length minus delta
  logic [COUNT_BITS-1:0] dlt_q, dlt_d;
  logic [COUNT_BITS-1:0] rem_q, rem_d;

  logic [ACC_W-1:0] acc_sub;
  logic [ACC_W-1:0] acc_wrap;
  logic             acc_neg;
  logic             rem_nz;

  // Both outcomes in parallel: acc - delta and acc - delta + length
  assign acc_sub  = acc_q - {2'b00, dlt_q};
  assign acc_wrap = acc_q + back_q;
  assign acc_neg  = acc_sub[ACC_W-1];
  assign rem_nz   = (rem_q != '0);

  // Next state
  always_comb begin
    acc_d  = acc_q;
    back_d = back_q;
    dlt_d  = dlt_q;
    rem_d  = rem_q;
    if (ctrl_i.load) begin
      acc_d  = '0 - {3'b000, len_i[COUNT_BITS-1:1]};
      back_d = {2'b00, len_i} - {2'b00, delta_i};
      dlt_d  = delta_i;
      rem_d  = delta_i;
    end else if (ctrl_i.tick && rem_nz) begin
      if (acc_neg) begin
        acc_d = acc_wrap;
        rem_d = rem_q - 1'b1;
      end else begin
        acc_d = acc_sub;
      end
    end
  end

  assign stat_o.step    = ctrl_i.tick && rem_nz && acc_neg;
  assign stat_o.pending = (rem_d != '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q  <= '0;
      back_q <= '0;
      dlt_q  <= '0;
      rem_q  <= '0;
    end else begin
      acc_q  <= acc_d;
      back_q <= back_d;
      dlt_q  <= dlt_d;
      rem_q  <= rem_d;
    end
  end

endmodule

// ===== hdl/multi_axis_dda_step_generator.sv =====
// The result is registered: it enters the output register after its input has passed the input register.
// Throughput: one item per cycle unless stalled; each axis does one parallel add/compare per tick.
// Input register -> per-axis update -> result register; backpressure stalls the input side.
// Reset (rst_ni low, asynchronous): move idle, all counters and accumulators zero.
// Depends on mad_pkg, mad_axis and the assertion macro header.
`include "multi_axis_dda_step_generator_assert.svh"

module multi_axis_dda_step_generator
  import mad_pkg::*;
#(
  parameter int unsigned AXES       = AXES_DEF,
  parameter int unsigned COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // tdata: axis0_delta, axis1_delta, axis2_delta, axis3_delta, total_count, dir_in
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata_i,
  input  logic                   s_axis_tuser_i,   // opcode
  input  logic                   s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  // tdata: step_mask, dir_out, busy_res, tick_index
  output logic [OUT_TDATA_W-1:0] m_axis_tdata_o,
  output logic                   m_axis_tlast_o,   // finished
  output logic                   m_axis_tvalid_o,
  input  logic                   m_axis_tready_i
);

  // Input register
  logic                  in_valid_q, in_valid_d;
  mad_op_e               in_op_q;
  logic [COUNT_BITS-1:0] in_dlt_q [AXES];
  logic [COUNT_BITS-1:0] in_len_q;
  logic [AXES-1:0]       in_dir_q;

  // Move state
  logic              live_q, live_d;
  logic [AXES-1:0]   dir_q, dir_d;
  logic [TICK_W-1:0] tick_q, tick_d;

  // Result register
  logic              out_valid_q, out_valid_d;
  logic [MASK_W-1:0] out_step_q, out_step_d;
  logic [MASK_W-1:0] out_dir_q, out_dir_d;
  logic              out_busy_q, out_busy_d;
  logic              out_fin_q, out_fin_d;
  logic [TICK_W-1:0] out_tick_q, out_tick_d;

  logic           s_xfer;
  logic           adv;
  mad_axis_ctrl_t axis_ctrl;
  mad_axis_stat_t axis_stat [AXES];
  logic [AXES-1:0] step_vec;
  logic [AXES-1:0] pend_vec;

  // Handshake: the input register moves on when the result register is free
  assign adv             = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || adv;
  assign s_xfer          = s_axis_tvalid_i && s_axis_tready_o;

  always_comb begin
    in_valid_d = in_valid_q;
    if (s_xfer) begin
      in_valid_d = 1'b1;
    end else if (adv) begin
      in_valid_d = 1'b0;
    end
  end

  // Input payload capture
  always_ff @(posedge clk_i) begin
    if (s_xfer) begin
      in_op_q  <= mad_op_e'(s_axis_tuser_i);
      for (int a = 0; a < AXES; a++) begin
        in_dlt_q[a] <= s_axis_tdata_i[a*FIELD_W +: COUNT_BITS];
      end
      in_len_q <= s_axis_tdata_i[LEN_LSB +: COUNT_BITS];
      in_dir_q <= s_axis_tdata_i[DIR_LSB +: AXES];
    end
  end

  // Axis control
  assign axis_ctrl.load = adv && (in_op_q == MAD_OP_START);
  assign axis_ctrl.tick = adv && (in_op_q == MAD_OP_TICK) && live_q;

  // Axis datapaths
  for (genvar g = 0; g < AXES; g++) begin : g_axis
    mad_axis #(
      .COUNT_BITS (COUNT_BITS)
    ) u_axis (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (axis_ctrl),
      .delta_i (in_dlt_q[g]),
      .len_i   (in_len_q),
      .stat_o  (axis_stat[g])
    );
    assign step_vec[g] = axis_stat[g].step;
    assign pend_vec[g] = axis_stat[g].pending;
  end

  // Move sequencing and result
  always_comb begin
    live_d     = live_q;
    dir_d      = dir_q;
    tick_d     = tick_q;
    out_step_d = '0;
    out_dir_d  = MASK_W'(dir_q);
    out_busy_d = live_q;
    out_fin_d  = 1'b0;
    out_tick_d = tick_q;
    if (axis_ctrl.load) begin
      live_d     = 1'b1;
      dir_d      = in_dir_q;
      tick_d     = '0;
      out_dir_d  = MASK_W'(in_dir_q);
      out_busy_d = 1'b1;
      out_tick_d = '0;
    end else if (axis_ctrl.tick) begin
      tick_d     = tick_q + 1'b1;
      live_d     = |pend_vec;
      out_step_d = MASK_W'(step_vec);
      out_busy_d = |pend_vec;
      out_fin_d  = ~|pend_vec;
      out_tick_d = tick_q + 1'b1;
    end
  end

  // Result register valid
  always_comb begin
    out_valid_d = out_valid_q;
    if (adv) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      live_q      <= 1'b0;
      dir_q       <= '0;
      tick_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      live_q      <= live_d;
      dir_q       <= dir_d;
      tick_q      <= tick_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_step_q <= out_step_d;
      out_dir_q  <= out_dir_d;
      out_busy_q <= out_busy_d;
      out_fin_q  <= out_fin_d;
      out_tick_q <= out_tick_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tlast_o  = out_fin_q;
  assign m_axis_tdata_o  = OUT_TDATA_W'({out_tick_q, out_busy_q, out_dir_q, out_step_q});

  // Checks
  `MAD_ASSERT_ALWAYS(a_rst_idle, clk_i, !rst_ni |=> (!m_axis_tvalid_o && !live_q), "not idle in reset")
  `MAD_ASSERT(a_stall_hold, clk_i, rst_ni, (out_valid_q && !m_axis_tready_i) |-> !adv, "result overwritten while stalled")
  `MAD_ASSERT(a_fin_ends, clk_i, rst_ni, (adv && out_fin_d) |=> (!live_q && m_axis_tlast_o), "finished move still live")
  `MAD_ASSERT(a_start_clr, clk_i, rst_ni, axis_ctrl.load |=> (live_q && tick_q == '0), "start did not clear tick count")
  `MAD_ASSERT(a_step_live, clk_i, rst_ni, (out_valid_q && out_step_q != '0) |-> (out_busy_q || out_fin_q), "step outside a move")

endmodule

// ===== tb/tb.sv =====
// Testbench for multi_axis_dda_step_generator: directed table plus random moves,
// every result checked against a typed-in value or a local DDA predictor. Depends on mad_pkg.
`timescale 1ns / 1ps

module tb;
  import mad_pkg::*;

  localparam int unsigned HALF_PERIOD = 6;
  localparam int unsigned RAND_ITEMS  = 630;
  localparam int unsigned CALM_FIRST  = 300;
  localparam int unsigned CALM_LAST   = 420;
  localparam int unsigned HOLD_AT     = 150;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned IDLE_PCT    = 24;

  // One input item, fields as the block sees them
  typedef struct {
    mad_op_e          op;
    logic [3:0][31:0] deltas;
    logic [31:0]      length;
    logic [3:0]       dir;
  } move_item_t;

  // One result item
  typedef struct packed {
    logic [3:0]  steps;
    logic [3:0]  dirs;
    logic        busy;
    logic        done;
    logic [31:0] ticks;
  } step_result_t;

  // Directed row: item plus an optional typed-in result
  typedef struct {
    move_item_t   item;
    logic         typed;
    step_result_t want;
  } vector_row_t;

  logic                   clk_i;
  logic                   rst_ni;
  logic [IN_TDATA_W-1:0]  s_axis_tdata_i;
  logic                   s_axis_tuser_i;
  logic                   s_axis_tvalid_i;
  logic                   s_axis_tready_o;
  logic [OUT_TDATA_W-1:0] m_axis_tdata_o;
  logic                   m_axis_tlast_o;
  logic                   m_axis_tvalid_o;
  logic                   m_axis_tready_i;

  multi_axis_dda_step_generator dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i)
  );

  // Predictor state
  logic [3:0][33:0] acc_q;
  logic [3:0][31:0] left_q;
  logic [3:0][31:0] delta_q;
  logic [31:0]      len_q;
  logic [3:0]       dir_q;
  logic             live_q;
  logic [31:0]      ticks_q;

  step_result_t step_q[$];
  int unsigned  errors;
  int unsigned  items_sent;
  int unsigned  results_seen;
  logic         calm;

  initial clk_i = 1'b0;
  always #(HALF_PERIOD) clk_i = ~clk_i;

  // Hard stop in case the handshakes hang
  initial begin
    #2_000_000;
    $display("Regression FAIL");
    $finish;
  end

  // Advance the DDA by one item and return the result it causes
  function automatic step_result_t dda_advance(input move_item_t it);
    step_result_t r;
    logic         any;
    logic [33:0]  acc;
    r = '0;
    if (it.op == MAD_OP_START) begin
      len_q = it.length;
      for (int a = 0; a < 4; a++) begin
        delta_q[a] = it.deltas[a];
        left_q[a]  = it.deltas[a];
        acc_q[a]   = 34'd0 - {2'b00, it.length >> 1};
      end
      dir_q   = it.dir;
      ticks_q = '0;
      live_q  = 1'b1;
    end else if (live_q) begin
      any = 1'b0;
      for (int a = 0; a < 4; a++) begin
        if (left_q[a] != 0) begin
          acc = acc_q[a] - {2'b00, delta_q[a]};
          if (acc[33]) begin
            r.steps[a] = 1'b1;
            left_q[a]  = left_q[a] - 1;
            acc        = acc + {2'b00, len_q};
          end
          acc_q[a] = acc;
        end
        if (left_q[a] != 0) any = 1'b1;
      end
      ticks_q = ticks_q + 1;
      if (!any) begin
        live_q = 1'b0;
        r.done = 1'b1;
      end
    end
    r.dirs  = dir_q;
    r.busy  = live_q;
    r.ticks = ticks_q;
    return r;
  endfunction

  function automatic move_item_t mk_item(input mad_op_e op, input logic [31:0] d0,
                                         input logic [31:0] d1, input logic [31:0] d2,
                                         input logic [31:0] d3, input logic [31:0] len,
                                         input logic [3:0] dir);
    move_item_t it;
    it.op     = op;
    it.deltas = {d3, d2, d1, d0};
    it.length = len;
    it.dir    = dir;
    return it;
  endfunction

  function automatic step_result_t mk_res(input logic [3:0] steps, input logic [3:0] dirs,
                                          input logic busy, input logic done,
                                          input logic [31:0] ticks);
    step_result_t r;
    r.steps = steps;
    r.dirs  = dirs;
    r.busy  = busy;
    r.done  = done;
    r.ticks = ticks;
    return r;
  endfunction

  function automatic vector_row_t mk_row(input move_item_t it, input logic typed,
                                         input step_result_t want);
    vector_row_t row;
    row.item  = it;
    row.typed = typed;
    row.want  = want;
    return row;
  endfunction

  // Offer one item, with random gaps, and record its prediction on transfer.
  // Called right after a rising edge; returns in the step of the transfer.
  task automatic push_item(input move_item_t it);
    logic [191:0]          noise;
    logic [IN_TDATA_W-1:0] data;
    noise = {$urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom()};
    if (it.op == MAD_OP_START) begin
      data = '0;
      for (int a = 0; a < 4; a++) data[a*FIELD_W +: FIELD_W] = it.deltas[a];
      data[LEN_LSB +: FIELD_W] = it.length;
      data[DIR_LSB +: MASK_W]  = it.dir;
    end else begin
      // tick payload is ignored, so fill it with noise
      data = noise[IN_TDATA_W-1:0];
    end
    calm = (items_sent >= CALM_FIRST) && (items_sent < CALM_LAST);
    while (!calm && ($urandom_range(99) < IDLE_PCT)) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= it.op;
    s_axis_tdata_i  <= data;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    step_q.push_back(dda_advance(it));
    items_sent++;
  endtask

  // Result side: check on transfer, random backpressure, one long hold-off
  initial begin
    int unsigned hold_left;
    logic        held;
    step_result_t got;
    step_result_t want;
    m_axis_tready_i = 1'b0;
    errors          = 0;
    results_seen    = 0;
    hold_left       = 0;
    held            = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
        got.steps = m_axis_tdata_o[STEP_LSB +: MASK_W];
        got.dirs  = m_axis_tdata_o[DOUT_LSB +: MASK_W];
        got.busy  = m_axis_tdata_o[BUSY_BIT];
        got.done  = m_axis_tlast_o;
        got.ticks = m_axis_tdata_o[TICK_LSB +: TICK_W];
        results_seen++;
        if (step_q.size() == 0) begin
          $error("result with no expectation: tdata=%h tlast=%b", m_axis_tdata_o,
                 m_axis_tlast_o);
          errors++;
        end else begin
          want = step_q.pop_front();
          if (got.steps !== want.steps) begin
            $error("step_mask: expected %h, got %h", want.steps, got.steps);
            errors++;
          end
          if (got.dirs !== want.dirs) begin
            $error("dir_out: expected %h, got %h", want.dirs, got.dirs);
            errors++;
          end
          if (got.busy !== want.busy) begin
            $error("busy_res: expected %b, got %b", want.busy, got.busy);
            errors++;
          end
          if (got.done !== want.done) begin
            $error("finished: expected %b, got %b", want.done, got.done);
            errors++;
          end
          if (got.ticks !== want.ticks) begin
            $error("tick_index: expected %0d, got %0d", want.ticks, got.ticks);
            errors++;
          end
        end
      end
      if (!held && results_seen >= HOLD_AT) begin
        held      = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready_i <= 1'b0;
      end else if (calm) begin
        m_axis_tready_i <= 1'b1;
      end else begin
        m_axis_tready_i <= ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // Stimulus
  initial begin
    vector_row_t      rows[$];
    move_item_t       tick;
    move_item_t       it;
    int unsigned      rand_sent;
    int unsigned      kind;
    int unsigned      extra;
    int unsigned      cap;
    logic [31:0]      len;
    logic [3:0][31:0] d;
    step_result_t     none;

    rst_ni          = 1'b0;
    s_axis_tdata_i  = '0;
    s_axis_tuser_i  = MAD_OP_TICK;
    s_axis_tvalid_i = 1'b0;
    items_sent      = 0;
    calm            = 1'b0;
    acc_q   = '0;
    left_q  = '0;
    delta_q = '0;
    len_q   = '0;
    dir_q   = '0;
    live_q  = 1'b0;
    ticks_q = '0;
    none = '0;
    tick = mk_item(MAD_OP_TICK, 0, 0, 0, 0, 0, 4'h0);

    // idle tick straight after reset
    rows.push_back(mk_row(tick, 1'b1, mk_res(4'h0, 4'h0, 1'b0, 1'b0, 0)));
    // move with all counts zero: first tick finishes with no steps
    rows.push_back(mk_row(mk_item(MAD_OP_START, 0, 0, 0, 0, 0, 4'hF), 1'b1,
                          mk_res(4'h0, 4'hF, 1'b1, 1'b0, 0)));
    rows.push_back(mk_row(tick, 1'b1, mk_res(4'h0, 4'hF, 1'b0, 1'b1, 1)));
    // idle tick holds the last count
    rows.push_back(mk_row(tick, 1'b1, mk_res(4'h0, 4'hF, 1'b0, 1'b0, 1)));
    // ordinary short move
    rows.push_back(mk_row(mk_item(MAD_OP_START, 3, 1, 2, 0, 3, 4'h5), 1'b1,
                          mk_res(4'h0, 4'h5, 1'b1, 1'b0, 0)));
    repeat (4) rows.push_back(mk_row(tick, 1'b0, none));
    // all fields at their maximum
    rows.push_back(mk_row(mk_item(MAD_OP_START, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                  32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'hA), 1'b1,
                          mk_res(4'h0, 4'hA, 1'b1, 1'b0, 0)));
    repeat (3) rows.push_back(mk_row(tick, 1'b0, none));
    // deltas above the move length: accumulators wrap
    rows.push_back(mk_row(mk_item(MAD_OP_START, 10, 5, 0, 7, 4, 4'h3), 1'b1,
                          mk_res(4'h0, 4'h3, 1'b1, 1'b0, 0)));
    repeat (4) rows.push_back(mk_row(tick, 1'b0, none));
    // zero move length with nonzero deltas
    rows.push_back(mk_row(mk_item(MAD_OP_START, 1, 0, 0, 2, 0, 4'hC), 1'b1,
                          mk_res(4'h0, 4'hC, 1'b1, 1'b0, 0)));
    repeat (1) rows.push_back(mk_row(tick, 1'b0, none));
    // restart in the middle of a live move, top bits set
    rows.push_back(mk_row(mk_item(MAD_OP_START, 32'h8000_0000, 32'h4000_0001, 32'h0000_0001,
                                  32'h7FFF_FFFF, 32'h8000_0000, 4'h9), 1'b1,
                          mk_res(4'h0, 4'h9, 1'b1, 1'b0, 0)));
    repeat (2) rows.push_back(mk_row(tick, 1'b0, none));

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table
    foreach (rows[i]) begin
      push_item(rows[i].item);
      if (rows[i].typed) step_q[$] = rows[i].want;
    end

    // random moves, mostly well formed
    rand_sent = 0;
    while (rand_sent < RAND_ITEMS) begin
      kind = $urandom_range(99);
      if (kind < 70) begin
        len = $urandom_range(24, 1);
        for (int a = 0; a < 4; a++) d[a] = $urandom_range(len, 0);
        d[$urandom_range(3)] = len;
        cap = 200;
      end else if (kind < 85) begin
        len = $urandom();
        for (int a = 0; a < 4; a++) d[a] = $urandom();
        cap = $urandom_range(6, 1);
      end else begin
        len = $urandom_range(6, 0);
        for (int a = 0; a < 4; a++) d[a] = $urandom_range(15, 0);
        cap = 40;
      end
      it = mk_item(MAD_OP_START, d[0], d[1], d[2], d[3], len, 4'($urandom()));
      push_item(it);
      rand_sent++;
      while (live_q && cap > 0 && rand_sent < RAND_ITEMS) begin
        push_item(tick);
        rand_sent++;
        cap--;
      end
      // an occasional tick past the end of the move
      extra = $urandom_range(2, 0);
      repeat (extra) begin
        push_item(tick);
        rand_sent++;
      end
    end
    s_axis_tvalid_i <= 1'b0;

    // drain, then allow for the pipeline
    while (step_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/mad_pkg.sv
hdl/mad_axis.sv
hdl/multi_axis_dda_step_generator.sv
tb/tb.sv
